FILE: hw/rtl/gcs_pkg.sv
// gcs_pkg: shared constants for the gcd complement sum block
// no dependencies; imported by gcs_gcd_unit, gcd_complement_sum and gcd_complement_sum_tb
`timescale 1ns / 1ps

package gcs_pkg;

    localparam int MODULUS_BITS_DEF = 16;
    localparam int TRAP_BITS        = 32;

endpackage

FILE: hw/rtl/gcs_gcd_unit.sv
// gcs_gcd_unit: iterative binary gcd, one shift, swap or subtract per cycle
// depends on gcs_pkg; both operands must be nonzero at start
`timescale 1ns / 1ps

module gcs_gcd_unit #(
    parameter int WIDTH = gcs_pkg::MODULUS_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             done,
    output logic [WIDTH-1:0] gcd
);
    import gcs_pkg::*;

    localparam int SHIFT_BITS = $clog2(WIDTH);

    logic                  run_reg;
    logic                  run_next;
    logic                  done_reg;
    logic                  done_next;
    logic [WIDTH-1:0]      a_reg;
    logic [WIDTH-1:0]      a_next;
    logic [WIDTH-1:0]      b_reg;
    logic [WIDTH-1:0]      b_next;
    logic [SHIFT_BITS-1:0] shift_reg;
    logic [SHIFT_BITS-1:0] shift_next;
    logic [WIDTH-1:0]      gcd_reg;
    logic [WIDTH-1:0]      gcd_next;

    // the one subtractor; its borrow doubles as the magnitude compare
    logic [WIDTH:0]        diff;
    logic                  a_less;
    logic                  equal;

    assign diff   = {1'b0, a_reg} - {1'b0, b_reg};
    assign a_less = diff[WIDTH];
    assign equal  = (a_reg == b_reg);

    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        shift_next = shift_reg;
        gcd_next   = gcd_reg;
        if (start)
        begin
            run_next   = 1'b1;
            a_next     = a;
            b_next     = b;
            shift_next = '0;
        end
        else if (run_reg)
        begin
            if (equal)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                gcd_next  = a_reg << shift_reg;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next     = a_reg >> 1;
                b_next     = b_reg >> 1;
                shift_next = shift_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_less)
            begin
                // both odd, keep the larger one in a
                a_next = b_reg;
                b_next = a_reg;
            end
            else
            begin
                // odd minus odd is even, so halve right away
                a_next = diff[WIDTH:1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        shift_reg <= shift_next;
        gcd_reg   <= gcd_next;
    end

    assign done = done_reg;
    assign gcd  = gcd_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("gcd unit restarted while running");

    a_operands_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (a_reg != '0) && (b_reg != '0))
        else $error("gcd operand reached zero");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("gcd done while still running");

endmodule

FILE: hw/rtl/gcd_complement_sum.sv
// gcd_complement_sum: sums m - gcd(k, m) over k = 1..m on one shared gcd unit
// depends on gcs_pkg and gcs_gcd_unit
// sequence: a zero modulus gives done straight from idle; else each k = 1..m passes through
// the issue and wait states while the gcd unit runs its binary shift or subtract steps
// throughput: one word at a time; busy stays high until the result strobe, not set for m = 0
// done is high for one cycle as the result shows on trap_count, held until the next; receiver cannot stall
// reset: asynchronous active low, clears the sequencer and the strobe
`timescale 1ns / 1ps

module gcd_complement_sum #(
    parameter int MODULUS_BITS = gcs_pkg::MODULUS_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [MODULUS_BITS-1:0]        modulus,
    output logic                           done,
    output logic [gcs_pkg::TRAP_BITS-1:0]  trap_count
);
    import gcs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [MODULUS_BITS-1:0] m_reg;
    logic [MODULUS_BITS-1:0] m_next;
    logic [MODULUS_BITS-1:0] k_reg;
    logic [MODULUS_BITS-1:0] k_next;
    logic [TRAP_BITS-1:0]    total_reg;
    logic [TRAP_BITS-1:0]    total_next;
    logic                    done_reg;
    logic                    done_next;
    logic [TRAP_BITS-1:0]    trap_reg;
    logic [TRAP_BITS-1:0]    trap_next;

    logic                    gcd_start;
    logic                    gcd_done;
    logic [MODULUS_BITS-1:0] gcd_value;
    logic [TRAP_BITS-1:0]    sum;

    gcs_gcd_unit #(
        .WIDTH (MODULUS_BITS)
    ) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .a     (k_reg),
        .b     (m_reg),
        .done  (gcd_done),
        .gcd   (gcd_value)
    );

    // total wraps to the low bits of the result width
    assign sum       = total_reg + TRAP_BITS'(m_reg - gcd_value);
    assign gcd_start = (state_reg == ST_ISSUE);

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        total_next = total_reg;
        done_next  = 1'b0;
        trap_next  = trap_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    m_next     = modulus;
                    k_next     = {{(MODULUS_BITS-1){1'b0}}, 1'b1};
                    total_next = '0;
                    if (modulus == '0)
                    begin
                        done_next = 1'b1;
                        trap_next = '0;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (gcd_done)
                begin
                    total_next = sum;
                    if (k_reg == m_reg)
                    begin
                        done_next  = 1'b1;
                        trap_next  = sum;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        k_reg     <= k_next;
        total_reg <= total_next;
        trap_reg  <= trap_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign trap_count = trap_reg;

    a_finish_strobes: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("left busy without a result");

    a_zero_modulus: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (modulus == '0)) |=> done && (trap_count == '0))
        else $error("zero modulus did not give zero at once");

    a_gcd_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && gcd_done) |-> (gcd_value != '0) && (gcd_value <= m_reg))
        else $error("gcd out of range");

    a_k_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (k_reg != '0) && (k_reg <= m_reg))
        else $error("k stepped past the modulus");

endmodule

FILE: dv/gcd_complement_sum_tb.sv
// gcd_complement_sum_tb: self-checking bench for the gcd complement sum block
// depends on gcs_pkg and the gcd_complement_sum rtl; predicts each count with a euclid loop
`timescale 1ns / 1ps

module gcd_complement_sum_tb;

    import gcs_pkg::*;

    localparam int M_BITS = MODULUS_BITS_DEF;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [M_BITS-1:0]    modulus = '0;
    logic                 busy;
    logic                 done;
    logic [TRAP_BITS-1:0] trap_count;

    logic [TRAP_BITS-1:0] expected_counts[$];
    int unsigned          error_count = 0;
    int unsigned          sender_idle_pct = 0;

    gcd_complement_sum #(
        .MODULUS_BITS(M_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .modulus   (modulus),
        .done      (done),
        .trap_count(trap_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sum over k = 1..m of m - gcd(k, m), low 32 bits
    function automatic logic [TRAP_BITS-1:0] trap_count_of(logic [M_BITS-1:0] m);
        longint unsigned total;
        longint unsigned a;
        longint unsigned b;
        longint unsigned r;
        total = 0;
        for (longint unsigned k = 1; k <= m; k++)
        begin
            a = k;
            b = m;
            while (b != 0)
            begin
                r = a % b;
                a = b;
                b = r;
            end
            total += m - a;
        end
        return total[TRAP_BITS-1:0];
    endfunction

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        logic [TRAP_BITS-1:0] want;
        if (rst_n && done)
        begin
            if (expected_counts.size() == 0)
                report_error($sformatf("unexpected result word trap_count=%0d", trap_count));
            else
            begin
                want = expected_counts.pop_front();
                if (trap_count !== want)
                    report_error($sformatf("trap_count mismatch: expected %0d, got %0d",
                                           want, trap_count));
            end
        end
    end

    // present one word, hold start until busy drops, then maybe idle for a while
    task automatic send_word(logic [M_BITS-1:0] m);
        int unsigned gap;
        start   <= 1'b1;
        modulus <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_counts.push_back(trap_count_of(m));
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off new words until every pending result is back
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_counts.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_small_moduli();
        logic [M_BITS-1:0] picks[] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd0, 16'd4, 16'd7,
                                       16'd12, 16'd16, 16'd30, 16'd97, 16'd128, 16'd255,
                                       16'd256, 16'd360, 16'd1023, 16'd1024};
        sender_idle_pct = 0;
        foreach (picks[i])
            send_word(picks[i]);
        wait_for_drain();
    endtask

    // all ones: longest run and the only word reaching the upper bits
    task automatic test_max_modulus();
        sender_idle_pct = 0;
        send_word({M_BITS{1'b1}});
        send_word('0);
        wait_for_drain();
    endtask

    task automatic test_random_moduli();
        int unsigned idle_phases[4] = '{0, 47, 0, 11};
        int unsigned sel;
        logic [M_BITS-1:0] m;
        foreach (idle_phases[p])
        begin
            sender_idle_pct = idle_phases[p];
            repeat (25)
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                    m = M_BITS'($urandom_range(0, 63));
                else if (sel < 95)
                    m = M_BITS'($urandom_range(64, 511));
                else
                    m = M_BITS'($urandom_range(512, 1023));
                send_word(m);
            end
            wait_for_drain();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_moduli();
        test_max_modulus();
        test_random_moduli();

        start <= 1'b0;
        repeat (20) @(posedge clk);
        if (expected_counts.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_counts.size()));

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #300_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
